@@ sv/rate_monotonic_tick_scheduler_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Rate-monotonic tick scheduler assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef RATE_MONOTONIC_TICK_SCHEDULER_UNIT_MACROS_SVH
`define RATE_MONOTONIC_TICK_SCHEDULER_UNIT_MACROS_SVH

// The property holds at every clock edge outside reset.
`define RMTS_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// When the trigger holds, the consequence holds in the next cycle.
`define RMTS_ASSERT_NEXT(name, trig, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) else $error(msg);

`endif

@@ sv/rmts_pkg.sv @@
// ----------------------------------------------------------------------------
// Rate-monotonic tick scheduler package
// Sizes, command and record codes, and the structs passed between modules.
// ----------------------------------------------------------------------------
package rmts_pkg;

   localparam int NUM_SLOTS = 8;
   localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int SLOT_IN_W = 3;
   localparam int TIME_W    = 16;
   localparam int TICK_W    = 32;
   localparam int LEN_W     = 32;

   localparam logic [TICK_W-1:0] TICK_ONES = '1;
   localparam logic [LEN_W-1:0]  LEN_ONES  = '1;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_TICK  = 2'd1;
   localparam logic [1:0] CMD_FLUSH = 2'd2;

   localparam logic [1:0] KIND_IDLE    = 2'd0;
   localparam logic [1:0] KIND_PREEMPT = 2'd1;
   localparam logic [1:0] KIND_FINISH  = 2'd2;
   localparam logic [1:0] KIND_FLUSH   = 2'd3;

   typedef struct packed {
      logic              load_en;
      logic [SLOT_W-1:0] load_slot;
      logic [TIME_W-1:0] load_period;
      logic [TIME_W-1:0] load_burst;
      logic [TIME_W-1:0] load_release;
      logic              scan_en;
      logic [SLOT_W-1:0] idx;
      logic [TICK_W-1:0] tick;
      logic              dec_en;
      logic [SLOT_W-1:0] dec_slot;
      logic [TIME_W-1:0] dec_value;
   } table_cmd_type;

   typedef struct packed {
      logic              active;
      logic [TIME_W-1:0] rem;
      logic [TIME_W-1:0] period;
   } slot_view_type;

   typedef struct packed {
      logic                 valid;
      logic [1:0]           kind;
      logic                 idle;
      logic [SLOT_IN_W-1:0] task_slot;
      logic [LEN_W-1:0]     length;
      logic                 last;
   } emit_type;

endpackage

@@ sv/rmts_task_table.sv @@
// ----------------------------------------------------------------------------
// Rate-monotonic tick scheduler task table
// Per-slot period, burst, remaining work, next release and active flag, with
// the release check and saturating next-release add for the indexed slot.
// ----------------------------------------------------------------------------
module rmts_task_table
   import rmts_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  table_cmd_type tcmd,
   output slot_view_type view
);

   logic [TIME_W-1:0]    period_ff  [NUM_SLOTS];
   logic [TIME_W-1:0]    burst_ff   [NUM_SLOTS];
   logic [TIME_W-1:0]    rem_ff     [NUM_SLOTS];
   logic [TICK_W-1:0]    nrel_ff    [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] active_ff;

   logic              hit;
   logic [TICK_W:0]   sum;
   logic [TICK_W-1:0] nrel_new;

   always_comb begin
      hit      = (nrel_ff[tcmd.idx] != TICK_ONES) && (nrel_ff[tcmd.idx] == tcmd.tick);
      sum      = {1'b0, tcmd.tick} + (TICK_W+1)'(period_ff[tcmd.idx]);
      nrel_new = sum[TICK_W] ? TICK_ONES : sum[TICK_W-1:0];
      view.active = active_ff[tcmd.idx] | hit;
      view.rem    = hit ? burst_ff[tcmd.idx] : rem_ff[tcmd.idx];
      view.period = period_ff[tcmd.idx];
   end

   always_ff @(posedge clock) begin
      if (tcmd.load_en) begin
         period_ff[tcmd.load_slot] <= tcmd.load_period;
         burst_ff[tcmd.load_slot]  <= tcmd.load_burst;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            rem_ff[i]  <= '0;
            nrel_ff[i] <= TICK_ONES;
         end
         active_ff <= '0;
      end else begin
         if (tcmd.load_en) begin
            rem_ff[tcmd.load_slot]    <= '0;
            nrel_ff[tcmd.load_slot]   <= TICK_W'(tcmd.load_release);
            active_ff[tcmd.load_slot] <= 1'b0;
         end
         if (tcmd.scan_en && hit) begin
            rem_ff[tcmd.idx]    <= burst_ff[tcmd.idx];
            nrel_ff[tcmd.idx]   <= nrel_new;
            active_ff[tcmd.idx] <= 1'b1;
         end
         if (tcmd.dec_en) begin
            rem_ff[tcmd.dec_slot] <= tcmd.dec_value;
            if (tcmd.dec_value == '0) begin
               active_ff[tcmd.dec_slot] <= 1'b0;
            end
         end
      end
   end

endmodule

@@ sv/rmts_sequencer.sv @@
// ----------------------------------------------------------------------------
// Rate-monotonic tick scheduler sequencer
// Walks the slots one per cycle to find the shortest-period ready task, then
// closes and opens run-length blocks and issues the record words.
// ----------------------------------------------------------------------------
`include "rate_monotonic_tick_scheduler_unit_macros.svh"

module rmts_sequencer
   import rmts_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_command,
   input  logic [SLOT_IN_W-1:0] req_slot,
   input  logic [TIME_W-1:0]    req_task_period,
   input  logic [TIME_W-1:0]    req_task_burst,
   input  logic [TIME_W-1:0]    req_first_release,
   output logic                 req_ready,
   input  slot_view_type        view,
   input  logic                 rsp_free,
   output table_cmd_type        tcmd,
   output emit_type             emit
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_CLOSE = 5'b00100,
      S_FIN   = 5'b01000,
      S_FLUSH = 5'b10000
   } state_type;

   localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic              best_valid_ff, best_valid_in;
   logic [SLOT_W-1:0] best_slot_ff, best_slot_in;
   logic [TIME_W-1:0] best_period_ff, best_period_in;
   logic [TIME_W-1:0] best_rem_ff, best_rem_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic              run_valid_ff, run_valid_in;
   logic [SLOT_W-1:0] run_slot_ff, run_slot_in;
   logic [LEN_W-1:0]  open_len_ff, open_len_in;

   logic              same;
   logic              need_close;
   logic              finish;
   logic [LEN_W-1:0]  len_base;
   logic [TICK_W-1:0] tick_next;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      best_valid_in  = best_valid_ff;
      best_slot_in   = best_slot_ff;
      best_period_in = best_period_ff;
      best_rem_in    = best_rem_ff;
      tick_in        = tick_ff;
      run_valid_in   = run_valid_ff;
      run_slot_in    = run_slot_ff;
      open_len_in    = open_len_ff;
      tcmd           = '0;
      tcmd.idx       = idx_ff;
      tcmd.tick      = tick_ff;
      emit           = '0;
      same       = best_valid_ff ? (run_valid_ff && (run_slot_ff == best_slot_ff))
                                 : !run_valid_ff;
      need_close = !same && (open_len_ff != '0);
      finish     = best_valid_ff && (best_rem_ff == TIME_W'(1));
      len_base   = need_close ? '0 : open_len_ff;
      tick_next  = (tick_ff == TICK_ONES) ? tick_ff : tick_ff + TICK_W'(1);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_command)
                  CMD_LOAD: begin
                     if ((tick_ff == '0) && (32'(req_slot) < NUM_SLOTS)) begin
                        tcmd.load_en      = 1'b1;
                        tcmd.load_slot    = SLOT_W'(req_slot);
                        tcmd.load_period  = req_task_period;
                        tcmd.load_burst   = req_task_burst;
                        tcmd.load_release = req_first_release;
                     end
                  end
                  CMD_TICK: begin
                     idx_in        = '0;
                     best_valid_in = 1'b0;
                     state_in      = S_SCAN;
                  end
                  CMD_FLUSH: begin
                     if (open_len_ff != '0) begin
                        state_in = S_FLUSH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            tcmd.scan_en = 1'b1;
            if (view.active && (view.rem != '0) &&
                (!best_valid_ff || (view.period < best_period_ff))) begin
               best_valid_in  = 1'b1;
               best_slot_in   = idx_ff;
               best_period_in = view.period;
               best_rem_in    = view.rem;
            end
            if (idx_ff == LAST_IDX) begin
               state_in = S_CLOSE;
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end
         S_CLOSE: begin
            if (!need_close || rsp_free) begin
               emit.valid     = need_close;
               emit.kind      = run_valid_ff ? KIND_PREEMPT : KIND_IDLE;
               emit.idle      = !run_valid_ff;
               emit.task_slot = run_valid_ff ? SLOT_IN_W'(run_slot_ff) : '0;
               emit.length    = open_len_ff;
               emit.last      = !finish;
               open_len_in    = (len_base == LEN_ONES) ? len_base : len_base + LEN_W'(1);
               run_valid_in   = best_valid_ff;
               run_slot_in    = best_valid_ff ? best_slot_ff : '0;
               if (best_valid_ff) begin
                  tcmd.dec_en    = 1'b1;
                  tcmd.dec_slot  = best_slot_ff;
                  tcmd.dec_value = best_rem_ff - TIME_W'(1);
               end
               if (finish) begin
                  state_in = S_FIN;
               end else begin
                  tick_in  = tick_next;
                  state_in = S_IDLE;
               end
            end
         end
         S_FIN: begin
            if (rsp_free) begin
               emit.valid     = 1'b1;
               emit.kind      = KIND_FINISH;
               emit.idle      = 1'b0;
               emit.task_slot = SLOT_IN_W'(best_slot_ff);
               emit.length    = open_len_ff;
               emit.last      = 1'b1;
               open_len_in    = '0;
               run_valid_in   = 1'b0;
               run_slot_in    = '0;
               tick_in        = tick_next;
               state_in       = S_IDLE;
            end
         end
         S_FLUSH: begin
            if (rsp_free) begin
               emit.valid     = 1'b1;
               emit.kind      = KIND_FLUSH;
               emit.idle      = !run_valid_ff;
               emit.task_slot = run_valid_ff ? SLOT_IN_W'(run_slot_ff) : '0;
               emit.length    = open_len_ff;
               emit.last      = 1'b1;
               open_len_in    = '0;
               run_valid_in   = 1'b0;
               run_slot_in    = '0;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         idx_ff        <= '0;
         best_valid_ff <= 1'b0;
         tick_ff       <= '0;
         run_valid_ff  <= 1'b0;
         run_slot_ff   <= '0;
         open_len_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         best_valid_ff <= best_valid_in;
         tick_ff       <= tick_in;
         run_valid_ff  <= run_valid_in;
         run_slot_ff   <= run_slot_in;
         open_len_ff   <= open_len_in;
      end
   end

   always_ff @(posedge clock) begin
      best_slot_ff   <= best_slot_in;
      best_period_ff <= best_period_in;
      best_rem_ff    <= best_rem_in;
   end

   `RMTS_ASSERT_ALWAYS(a_emit_state, !emit.valid || state_ff == S_CLOSE || state_ff == S_FIN || state_ff == S_FLUSH, "Record word issued outside a closing state.")
   `RMTS_ASSERT_ALWAYS(a_emit_len, !emit.valid || emit.length != '0, "Record word closes an empty block.")
   `RMTS_ASSERT_ALWAYS(a_fin_pick, state_ff != S_FIN || best_valid_ff, "Job finish without a picked task.")
   `RMTS_ASSERT_NEXT(a_fin_idle, state_ff == S_FIN && rsp_free, !run_valid_ff && open_len_ff == '0, "Open block not cleared after a job finished.")

endmodule

@@ sv/rate_monotonic_tick_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// Rate-monotonic tick scheduler unit
// Words are taken in the idle state only. A load is applied there; a tick
// passes the scan and close states, and the finish state when it finishes a
// job, as the sequencer reads one task slot per cycle through a single
// release-check and period compare path. Any cycle that issues a record
// waits while the output register holds a record that has not been taken.
// ----------------------------------------------------------------------------
module rate_monotonic_tick_scheduler_unit
   import rmts_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_command,
   input  logic [SLOT_IN_W-1:0] req_slot,
   input  logic [TIME_W-1:0]    req_task_period,
   input  logic [TIME_W-1:0]    req_task_burst,
   input  logic [TIME_W-1:0]    req_first_release,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_block_kind,
   output logic                 rsp_block_idle,
   output logic [SLOT_IN_W-1:0] rsp_block_task,
   output logic [LEN_W-1:0]     rsp_block_length,
   output logic                 rsp_last_record
);

   table_cmd_type tcmd;
   slot_view_type view;
   emit_type      emit;
   logic          rsp_free;

   logic                 rsp_valid_ff;
   logic [1:0]           kind_ff;
   logic                 idle_ff;
   logic [SLOT_IN_W-1:0] task_ff;
   logic [LEN_W-1:0]     length_ff;
   logic                 last_ff;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   rmts_task_table u_table (
      .clock (clock),
      .reset (reset),
      .tcmd  (tcmd),
      .view  (view)
   );

   rmts_sequencer u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_command       (req_command),
      .req_slot          (req_slot),
      .req_task_period   (req_task_period),
      .req_task_burst    (req_task_burst),
      .req_first_release (req_first_release),
      .req_ready         (req_ready),
      .view              (view),
      .rsp_free          (rsp_free),
      .tcmd              (tcmd),
      .emit              (emit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid) begin
         kind_ff   <= emit.kind;
         idle_ff   <= emit.idle;
         task_ff   <= emit.task_slot;
         length_ff <= emit.length;
         last_ff   <= emit.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_block_kind   = kind_ff;
   assign rsp_block_idle   = idle_ff;
   assign rsp_block_task   = task_ff;
   assign rsp_block_length = length_ff;
   assign rsp_last_record  = last_ff;

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// Rate-monotonic tick scheduler testbench
// Loads a task set that covers the field extremes, a zero burst, a zero
// period, a period tie and reloaded slots, then walks a directed table and a
// long random run of ticks, flushes and ignored words. Both sides idle and
// stall at random. Every record is checked against a directed row's expected
// record or a predictor of the schedule kept in step with each accepted word.
// ----------------------------------------------------------------------------
module tb;
   import rmts_pkg::*;

   localparam logic [1:0] CMD_NONE = 2'd3;
   localparam int NUM_DIRECTED = 23;
   localparam int RANDOM_WORDS = 1530;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [1:0]           kind;
      logic                 idle;
      logic [SLOT_IN_W-1:0] task_slot;
      logic [LEN_W-1:0]     length;
      logic                 last;
   } sched_rec_t;

   typedef struct packed {
      logic [1:0]           command;
      logic [SLOT_IN_W-1:0] slot;
      logic [TIME_W-1:0]    period;
      logic [TIME_W-1:0]    burst;
      logic [TIME_W-1:0]    first_rel;
      logic                 typed;
      logic                 typed_n;
      logic [1:0]           kind;
      logic                 idle;
      logic [SLOT_IN_W-1:0] task_slot;
      logic [LEN_W-1:0]     length;
   } stim_row_t;

   stim_row_t directed_rows [NUM_DIRECTED] = '{
      '{CMD_FLUSH, 3'd0, 16'd0,     16'd0,     16'd0,     1'b1, 1'b0, KIND_IDLE,  1'b0, 3'd0, 32'd0},
      '{CMD_NONE,  3'd7, 16'd65535, 16'd65535, 16'd65535, 1'b1, 1'b0, KIND_IDLE,  1'b0, 3'd0, 32'd0},
      '{CMD_LOAD,  3'd5, 16'd1,     16'd1,     16'd0,     1'b1, 1'b0, KIND_IDLE,  1'b0, 3'd0, 32'd0},
      '{CMD_LOAD,  3'd6, 16'd65535, 16'd65535, 16'd65535, 1'b1, 1'b0, KIND_IDLE,  1'b0, 3'd0, 32'd0},
      '{CMD_LOAD,  3'd0, 16'd20,    16'd2,     16'd0,     1'b1, 1'b0, KIND_IDLE,  1'b0, 3'd0, 32'd0},
      '{CMD_LOAD,  3'd1, 16'd7,     16'd2,     16'd1,     1'b1, 1'b0, KIND_IDLE,  1'b0, 3'd0, 32'd0},
      '{CMD_LOAD,  3'd2, 16'd65535, 16'd40,    16'd5,     1'b1, 1'b0, KIND_IDLE,  1'b0, 3'd0, 32'd0},
      '{CMD_LOAD,  3'd3, 16'd0,     16'd4,     16'd3,     1'b1, 1'b0, KIND_IDLE,  1'b0, 3'd0, 32'd0},
      '{CMD_LOAD,  3'd4, 16'd13,    16'd0,     16'd2,     1'b1, 1'b0, KIND_IDLE,  1'b0, 3'd0, 32'd0},
      '{CMD_LOAD,  3'd5, 16'd11,    16'd2,     16'd4,     1'b1, 1'b0, KIND_IDLE,  1'b0, 3'd0, 32'd0},
      '{CMD_LOAD,  3'd6, 16'd30,    16'd3,     16'd0,     1'b1, 1'b0, KIND_IDLE,  1'b0, 3'd0, 32'd0},
      '{CMD_LOAD,  3'd7, 16'd7,     16'd1,     16'd1,     1'b1, 1'b0, KIND_IDLE,  1'b0, 3'd0, 32'd0},
      '{CMD_TICK,  3'd0, 16'd0,     16'd0,     16'd0,     1'b1, 1'b0, KIND_IDLE,  1'b0, 3'd0, 32'd0},
      '{CMD_FLUSH, 3'd0, 16'd0,     16'd0,     16'd0,     1'b1, 1'b1, KIND_FLUSH, 1'b0, 3'd0, 32'd1},
      '{CMD_FLUSH, 3'd0, 16'd0,     16'd0,     16'd0,     1'b1, 1'b0, KIND_IDLE,  1'b0, 3'd0, 32'd0},
      '{CMD_TICK,  3'd0, 16'd0,     16'd0,     16'd0,     1'b0, 1'b0, KIND_IDLE,  1'b0, 3'd0, 32'd0},
      '{CMD_TICK,  3'd0, 16'd0,     16'd0,     16'd0,     1'b0, 1'b0, KIND_IDLE,  1'b0, 3'd0, 32'd0},
      '{CMD_TICK,  3'd0, 16'd0,     16'd0,     16'd0,     1'b0, 1'b0, KIND_IDLE,  1'b0, 3'd0, 32'd0},
      '{CMD_TICK,  3'd0, 16'd0,     16'd0,     16'd0,     1'b0, 1'b0, KIND_IDLE,  1'b0, 3'd0, 32'd0},
      '{CMD_TICK,  3'd0, 16'd0,     16'd0,     16'd0,     1'b0, 1'b0, KIND_IDLE,  1'b0, 3'd0, 32'd0},
      '{CMD_TICK,  3'd0, 16'd0,     16'd0,     16'd0,     1'b0, 1'b0, KIND_IDLE,  1'b0, 3'd0, 32'd0},
      '{CMD_LOAD,  3'd2, 16'd1,     16'd1,     16'd0,     1'b1, 1'b0, KIND_IDLE,  1'b0, 3'd0, 32'd0},
      '{CMD_NONE,  3'd0, 16'd0,     16'd0,     16'd0,     1'b1, 1'b0, KIND_IDLE,  1'b0, 3'd0, 32'd0}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_command = CMD_NONE;
   logic [SLOT_IN_W-1:0] req_slot = '0;
   logic [TIME_W-1:0]    req_task_period = '0;
   logic [TIME_W-1:0]    req_task_burst = '0;
   logic [TIME_W-1:0]    req_first_release = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [1:0]           rsp_block_kind;
   logic                 rsp_block_idle;
   logic [SLOT_IN_W-1:0] rsp_block_task;
   logic [LEN_W-1:0]     rsp_block_length;
   logic                 rsp_last_record;

   stim_row_t word_row = '0;

   logic [TIME_W-1:0] period_tab [NUM_SLOTS];
   logic [TIME_W-1:0] burst_tab [NUM_SLOTS];
   logic [TIME_W-1:0] work_left [NUM_SLOTS];
   logic [TICK_W-1:0] release_at [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] active;
   logic [TICK_W-1:0] ticks;
   logic [SLOT_IN_W-1:0] run_slot;
   logic run_valid;
   logic [LEN_W-1:0] open_len;

   sched_rec_t step_recs [$];
   sched_rec_t pending_records [$];

   int errors = 0;
   int cycle_count = 0;
   int tick_words = 0;
   int flush_words = 0;
   int load_words = 0;
   int other_words = 0;
   int records_checked = 0;
   logic send_quiet = 1'b0;
   logic take_quiet = 1'b0;

   rate_monotonic_tick_scheduler_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_slot(req_slot),
      .req_task_period(req_task_period),
      .req_task_burst(req_task_burst),
      .req_first_release(req_first_release),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_block_kind(rsp_block_kind),
      .rsp_block_idle(rsp_block_idle),
      .rsp_block_task(rsp_block_task),
      .rsp_block_length(rsp_block_length),
      .rsp_last_record(rsp_last_record)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic sched_rec_t make_rec(input logic [1:0] kind, input logic idle,
                                           input logic [SLOT_IN_W-1:0] slot,
                                           input logic [LEN_W-1:0] len);
      sched_rec_t r;
      r.kind = kind;
      r.idle = idle;
      r.task_slot = idle ? '0 : slot;
      r.length = len;
      r.last = 1'b0;
      return r;
   endfunction

   task automatic clear_schedule();
      for (int i = 0; i < NUM_SLOTS; i++) begin
         period_tab[i] = '0;
         burst_tab[i] = '0;
         work_left[i] = '0;
         release_at[i] = TICK_ONES;
      end
      active = '0;
      ticks = '0;
      run_slot = '0;
      run_valid = 1'b0;
      open_len = '0;
   endtask

   // Advances the schedule by one word and leaves the records it closes in step_recs.
   task automatic schedule_word(input stim_row_t w);
      int best;
      logic same;
      logic [TICK_W-1:0] nxt;
      sched_rec_t tail;
      step_recs.delete();
      case (w.command)
         CMD_LOAD: begin
            if (ticks == '0) begin
               period_tab[w.slot] = w.period;
               burst_tab[w.slot] = w.burst;
               release_at[w.slot] = {{(TICK_W-TIME_W){1'b0}}, w.first_rel};
               work_left[w.slot] = '0;
               active[w.slot] = 1'b0;
            end
         end
         CMD_TICK: begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (release_at[i] != TICK_ONES && release_at[i] == ticks) begin
                  nxt = ticks + {{(TICK_W-TIME_W){1'b0}}, period_tab[i]};
                  if (nxt < ticks) nxt = TICK_ONES;
                  active[i] = 1'b1;
                  work_left[i] = burst_tab[i];
                  release_at[i] = nxt;
               end
            end
            best = -1;
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (active[i] && work_left[i] != '0 &&
                   (best < 0 || period_tab[i] < period_tab[best])) best = i;
            end
            same = (best < 0) ? !run_valid : (run_valid && run_slot == SLOT_IN_W'(best));
            if (!same && open_len != '0) begin
               step_recs.push_back(make_rec(run_valid ? KIND_PREEMPT : KIND_IDLE, !run_valid,
                                            run_slot, open_len));
               open_len = '0;
            end
            run_valid = (best >= 0);
            run_slot = (best >= 0) ? SLOT_IN_W'(best) : '0;
            if (open_len != LEN_ONES) open_len = open_len + LEN_W'(1);
            if (run_valid) begin
               work_left[run_slot] = work_left[run_slot] - TIME_W'(1);
               if (work_left[run_slot] == '0) begin
                  active[run_slot] = 1'b0;
                  step_recs.push_back(make_rec(KIND_FINISH, 1'b0, run_slot, open_len));
                  open_len = '0;
                  run_valid = 1'b0;
                  run_slot = '0;
               end
            end
            if (ticks != TICK_ONES) ticks = ticks + TICK_W'(1);
         end
         CMD_FLUSH: begin
            if (open_len != '0) begin
               step_recs.push_back(make_rec(KIND_FLUSH, !run_valid, run_slot, open_len));
               open_len = '0;
               run_valid = 1'b0;
               run_slot = '0;
            end
         end
         default: begin
         end
      endcase
      if (step_recs.size() != 0) begin
         tail = step_recs.pop_back();
         tail.last = 1'b1;
         step_recs.push_back(tail);
      end
   endtask

   always @(posedge clock) begin
      sched_rec_t got;
      sched_rec_t want;
      if (reset) begin
         clear_schedule();
      end else if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run timed out with %0d records outstanding", $time,
                  pending_records.size());
         $display("Verification failed");
         $finish;
      end else begin
         cycle_count++;
         if (req_valid && req_ready) begin
            schedule_word(word_row);
            if (word_row.typed) begin
               if (word_row.typed_n) begin
                  want = make_rec(word_row.kind, word_row.idle, word_row.task_slot,
                                  word_row.length);
                  want.last = 1'b1;
                  pending_records.push_back(want);
               end
            end else begin
               foreach (step_recs[i]) pending_records.push_back(step_recs[i]);
            end
            case (word_row.command)
               CMD_TICK: tick_words++;
               CMD_FLUSH: flush_words++;
               CMD_LOAD: load_words++;
               default: other_words++;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_block_kind, rsp_block_idle, rsp_block_task, rsp_block_length,
                    rsp_last_record};
            records_checked++;
            if (pending_records.size() == 0) begin
               errors++;
               $display("%0t: unexpected record kind %0d idle %0d task %0d length %0d last %0d",
                        $time, got.kind, got.idle, got.task_slot, got.length, got.last);
            end else begin
               want = pending_records.pop_front();
               if (got !== want) begin
                  errors++;
                  $display("%0t: record mismatch, expected kind %0d idle %0d task %0d length %0d last %0d",
                           $time, want.kind, want.idle, want.task_slot, want.length, want.last);
                  $display("%0t:                  actual kind %0d idle %0d task %0d length %0d last %0d",
                           $time, got.kind, got.idle, got.task_slot, got.length, got.last);
               end
            end
         end
      end
   end

   task automatic send_word(input stim_row_t w);
      int gap;
      if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
      gap = send_quiet ? 0 : $urandom_range(0, 6);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= w.command;
      req_slot <= w.slot;
      req_task_period <= w.period;
      req_task_burst <= w.burst;
      req_first_release <= w.first_rel;
      word_row <= w;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) take_quiet = !take_quiet;
         stall = take_quiet ? 0 : $urandom_range(0, 6);
         repeat (stall) begin
            rsp_ready <= 1'b0;
            @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   initial begin
      stim_row_t w;
      int sel;
      int counted;
      while (reset) @(posedge clock);
      for (int i = 0; i < NUM_DIRECTED; i++) send_word(directed_rows[i]);

      // Loads are locked once ticking has started, so the random run is mostly
      // ticks over the loaded task set, with flushes and ignored words mixed in.
      counted = 0;
      while (counted < RANDOM_WORDS) begin
         w = '0;
         sel = $urandom_range(0, 99);
         if (sel < 88) w.command = CMD_TICK;
         else if (sel < 94) w.command = CMD_FLUSH;
         else if (sel < 97) w.command = CMD_LOAD;
         else w.command = CMD_NONE;
         w.slot = SLOT_IN_W'($urandom_range(0, 7));
         w.period = TIME_W'($urandom_range(0, 65535));
         w.burst = TIME_W'($urandom_range(0, 65535));
         w.first_rel = TIME_W'($urandom_range(0, 65535));
         counted++;
         send_word(w);
      end
      req_valid <= 1'b0;

      while (pending_records.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d ticks, %0d flushes, %0d loads and %0d unused commands.",
               tick_words, flush_words, load_words, other_words);
      $display("Checked %0d schedule records in %0d cycles, %0d errors.",
               records_checked, cycle_count, errors);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ rate_monotonic_tick_scheduler_unit.f @@
+incdir+sv
sv/rmts_pkg.sv
sv/rmts_task_table.sv
sv/rmts_sequencer.sv
sv/rate_monotonic_tick_scheduler_unit.sv
dv/tb.sv
